/* design/dmarb_pkg.sv */
// dmarb_pkg: types, codes and constants shared by the dma register block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dmarb_pkg;

  localparam int CHANNELS       = 7;
  localparam int CHANNEL_STRIDE = 16;

  localparam int ADDR_W = 7;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int CH_W   = 3;
  localparam int OFF_W  = $clog2(CHANNEL_STRIDE);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLR_TRIG = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLR_BUSY = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLR_BOTH = 3'd5;

  // register offsets
  localparam logic [ADDR_W-1:0] ADDR_PE    = 7'h70;
  localparam logic [ADDR_W-1:0] ADDR_IRQ   = 7'h74;
  localparam logic [OFF_W-1:0]  OFF_BASE   = 4'h0;
  localparam logic [OFF_W-1:0]  OFF_BLOCK  = 4'h4;
  localparam logic [OFF_W-1:0]  OFF_CTRL   = 4'h8;

  // channel control bits
  localparam int BIT_BUSY    = 24;
  localparam int BIT_TRIGGER = 28;
  localparam int SYNC_LSB    = 9;

  localparam logic [1:0] SYNC_MANUAL = 2'd0;
  localparam logic [1:0] SYNC_BLOCK  = 2'd1;
  localparam logic [1:0] SYNC_LIST   = 2'd2;

  // interrupt word layout
  localparam int IRQ_FORCE_BIT  = 15;
  localparam int IRQ_EN_LSB     = 16;
  localparam int IRQ_MEN_BIT    = 23;
  localparam int IRQ_FLAG_LSB   = 24;
  localparam int IRQ_MASTER_BIT = 31;
  localparam int IRQ_CH_W       = 7;

  localparam logic [DATA_W-1:0] IRQ_LOW_MASK   = 32'h00FF_FFFF;
  localparam logic [DATA_W-1:0] IRQ_FLAGS_MASK = 32'h7F00_0000;
  localparam logic [DATA_W-1:0] PE_RESET       = 32'h0FED_CBA9;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_COMPLETE,
    OP_CLR_TRIG,
    OP_CLR_BUSY,
    OP_CLR_BOTH
  } op_t;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_BASE,
    TGT_BLOCK,
    TGT_CTRL,
    TGT_PE,
    TGT_IRQ
  } tgt_t;

  typedef struct packed {
    op_t             op;
    tgt_t            tgt;
    logic [CH_W-1:0] ch;
  } dec_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              start_valid;
    logic [CH_W-1:0]   start_channel;
    logic              irq;
  } res_t;

endpackage

`default_nettype wire

/* design/dmarb_decode.sv */
// dmarb_decode: turns a registered item into an operation, target register and channel.
// Depends on dmarb_pkg.
`default_nettype none

module dmarb_decode (
  input  logic                        valid,
  input  logic [dmarb_pkg::KIND_W-1:0] kind,
  input  logic [dmarb_pkg::ADDR_W-1:0] address,
  input  logic [dmarb_pkg::CH_W-1:0]   channel,
  output dmarb_pkg::dec_t              dec
);
  import dmarb_pkg::*;

  logic [CH_W-1:0]  addr_ch;
  logic [OFF_W-1:0] addr_off;
  tgt_t             addr_tgt;
  logic             event_ok;

  assign addr_ch  = address[ADDR_W-1:OFF_W];
  assign addr_off = address[OFF_W-1:0];
  assign event_ok = (channel < CH_W'(CHANNELS));

  always_comb begin
    addr_tgt = TGT_NONE;
    if (address == ADDR_PE) begin
      addr_tgt = TGT_PE;
    end else if (address == ADDR_IRQ) begin
      addr_tgt = TGT_IRQ;
    end else if (addr_ch < CH_W'(CHANNELS)) begin
      case (addr_off)
        OFF_BASE:  addr_tgt = TGT_BASE;
        OFF_BLOCK: addr_tgt = TGT_BLOCK;
        OFF_CTRL:  addr_tgt = TGT_CTRL;
        default:   addr_tgt = TGT_NONE;
      endcase
    end
  end

  always_comb begin
    dec.op  = OP_NONE;
    dec.tgt = TGT_NONE;
    dec.ch  = '0;
    if (valid) begin
      case (kind)
        KIND_READ: begin
          dec.op  = OP_READ;
          dec.tgt = addr_tgt;
          dec.ch  = addr_ch;
        end
        KIND_WRITE: begin
          dec.op  = OP_WRITE;
          dec.tgt = addr_tgt;
          dec.ch  = addr_ch;
        end
        KIND_COMPLETE: begin
          dec.op = event_ok ? OP_COMPLETE : OP_NONE;
          dec.ch = channel;
        end
        KIND_CLR_TRIG: begin
          dec.op = event_ok ? OP_CLR_TRIG : OP_NONE;
          dec.ch = channel;
        end
        KIND_CLR_BUSY: begin
          dec.op = event_ok ? OP_CLR_BUSY : OP_NONE;
          dec.ch = channel;
        end
        KIND_CLR_BOTH: begin
          dec.op = event_ok ? OP_CLR_BOTH : OP_NONE;
          dec.ch = channel;
        end
        default: dec.op = OP_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/dmarb_regs.sv */
// dmarb_regs: channel, priority/enable and interrupt registers with their update rules.
// Depends on dmarb_pkg; driven by the decoded item from dmarb_decode.
`default_nettype none

module dmarb_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dmarb_pkg::dec_t              dec,
  input  logic [dmarb_pkg::DATA_W-1:0] wdata,
  output dmarb_pkg::res_t              res
);
  import dmarb_pkg::*;

  typedef logic [$clog2(DATA_W)-1:0] bit_idx_t;

  logic [DATA_W-1:0] chan_base_r  [CHANNELS];
  logic [DATA_W-1:0] chan_block_r [CHANNELS];
  logic [DATA_W-1:0] chan_ctrl_r  [CHANNELS];
  logic [DATA_W-1:0] chan_base_nxt  [CHANNELS];
  logic [DATA_W-1:0] chan_block_nxt [CHANNELS];
  logic [DATA_W-1:0] chan_ctrl_nxt  [CHANNELS];
  logic [DATA_W-1:0] pe_r, pe_nxt;
  logic [DATA_W-1:0] irq_r, irq_nxt;

  logic [DATA_W-1:0] irq_tmp;
  logic [DATA_W-1:0] clr_mask;
  logic [1:0]        sync;
  logic              start_ok;
  logic              start;
  logic [DATA_W-1:0] rd;
  bit_idx_t          en_idx;
  bit_idx_t          flag_idx;

  function automatic logic [DATA_W-1:0] with_master(input logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] r;
    r = w;
    r[IRQ_MASTER_BIT] = w[IRQ_FORCE_BIT] |
                        (w[IRQ_MEN_BIT] &
                         (|(w[IRQ_EN_LSB +: IRQ_CH_W] & w[IRQ_FLAG_LSB +: IRQ_CH_W])));
    return r;
  endfunction

  assign sync = wdata[SYNC_LSB +: 2];
  assign start_ok = wdata[BIT_BUSY] && pe_r[{dec.ch, 2'b11}] &&
                    ((sync == SYNC_BLOCK) || (sync == SYNC_LIST) ||
                     ((sync == SYNC_MANUAL) && wdata[BIT_TRIGGER]));
  // flag bits written as one are cleared
  assign clr_mask = wdata & IRQ_FLAGS_MASK;

  // enable and flag bit of the event's channel in the interrupt word
  assign en_idx   = bit_idx_t'(IRQ_EN_LSB) + bit_idx_t'(dec.ch);
  assign flag_idx = bit_idx_t'(IRQ_FLAG_LSB) + bit_idx_t'(dec.ch);

  always_comb begin
    chan_base_nxt  = chan_base_r;
    chan_block_nxt = chan_block_r;
    chan_ctrl_nxt  = chan_ctrl_r;
    pe_nxt   = pe_r;
    irq_nxt  = irq_r;
    irq_tmp  = irq_r;
    rd       = '0;
    start    = 1'b0;
    case (dec.op)
      OP_READ: begin
        case (dec.tgt)
          TGT_BASE:  rd = chan_base_r[dec.ch];
          TGT_BLOCK: rd = chan_block_r[dec.ch];
          TGT_CTRL:  rd = chan_ctrl_r[dec.ch];
          TGT_PE:    rd = pe_r;
          TGT_IRQ:   rd = irq_r;
          default:   rd = '0;
        endcase
      end
      OP_WRITE: begin
        case (dec.tgt)
          TGT_BASE:  chan_base_nxt[dec.ch]  = wdata;
          TGT_BLOCK: chan_block_nxt[dec.ch] = wdata;
          TGT_CTRL: begin
            chan_ctrl_nxt[dec.ch] = wdata;
            start = start_ok;
          end
          TGT_PE:    pe_nxt = wdata;
          TGT_IRQ: begin
            irq_tmp = ((irq_r & IRQ_FLAGS_MASK) | (wdata & IRQ_LOW_MASK)) & ~clr_mask;
            irq_nxt = with_master(irq_tmp);
          end
          default:   pe_nxt = pe_r;
        endcase
      end
      OP_COMPLETE: begin
        if (irq_r[en_idx]) begin
          irq_tmp[flag_idx] = 1'b1;
        end
        irq_nxt = with_master(irq_tmp);
      end
      OP_CLR_TRIG: chan_ctrl_nxt[dec.ch][BIT_TRIGGER] = 1'b0;
      OP_CLR_BUSY: chan_ctrl_nxt[dec.ch][BIT_BUSY] = 1'b0;
      OP_CLR_BOTH: begin
        chan_ctrl_nxt[dec.ch][BIT_TRIGGER] = 1'b0;
        chan_ctrl_nxt[dec.ch][BIT_BUSY]    = 1'b0;
      end
      default: rd = '0;
    endcase
  end

  assign res.read_data     = rd;
  assign res.start_valid   = start;
  assign res.start_channel = start ? dec.ch : '0;
  assign res.irq           = irq_nxt[IRQ_MASTER_BIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_base_r[i]  <= '0;
        chan_block_r[i] <= '0;
        chan_ctrl_r[i]  <= '0;
      end
      pe_r  <= PE_RESET;
      irq_r <= '0;
    end else begin
      chan_base_r  <= chan_base_nxt;
      chan_block_r <= chan_block_nxt;
      chan_ctrl_r  <= chan_ctrl_nxt;
      pe_r  <= pe_nxt;
      irq_r <= irq_nxt;
    end
  end

`ifndef SYNTHESIS
  a_master_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r[IRQ_MASTER_BIT] == (irq_r[IRQ_FORCE_BIT] |
      (irq_r[IRQ_MEN_BIT] &
       (|(irq_r[IRQ_EN_LSB +: IRQ_CH_W] & irq_r[IRQ_FLAG_LSB +: IRQ_CH_W])))))
    else $error("interrupt master flag out of step with its sources");

  a_pe_only_by_write: assert property (@(posedge clk) disable iff (!rst_n)
    (dec.op != OP_WRITE || dec.tgt != TGT_PE) |=> $stable(pe_r))
    else $error("priority/enable word changed without a write");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (dec.op == OP_CLR_BUSY || dec.op == OP_CLR_BOTH) |=>
      !chan_ctrl_r[$past(dec.ch)][BIT_BUSY])
    else $error("busy bit still set after a clear event");
`endif

endmodule

`default_nettype wire

/* design/dma_register_block.sv */
// dma_register_block: top level of the dma controller register block.
// Depends on dmarb_pkg, dmarb_decode and dmarb_regs.
`default_nettype none

// One item (read, write, completion or clear event) is accepted in every cycle in which
// start is high and busy is low; busy is high only during reset and is cleared once reset
// is released. An item is registered at acceptance, decoded and applied to the registers
// in the next cycle, and its result is registered again and shows on the out_ ports with
// out_strobe for exactly one cycle. The receiver cannot stall; results come in item
// order, and every item reads the register state left by all earlier items.
module dma_register_block (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dmarb_pkg::KIND_W-1:0] in_kind,
  input  logic [dmarb_pkg::ADDR_W-1:0] in_address,
  input  logic [dmarb_pkg::DATA_W-1:0] in_write_data,
  input  logic [dmarb_pkg::CH_W-1:0]   in_channel,
  output logic                         out_strobe,
  output logic [dmarb_pkg::DATA_W-1:0] out_read_data,
  output logic                         out_start_valid,
  output logic [dmarb_pkg::CH_W-1:0]   out_start_channel,
  output logic                         out_irq
);
  import dmarb_pkg::*;

  logic              busy_r;
  logic              in_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] address_r;
  logic [DATA_W-1:0] write_data_r;
  logic [CH_W-1:0]   channel_r;
  logic              accept;

  dec_t dec;
  res_t res;
  res_t res_r;
  logic strobe_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      in_valid_r <= 1'b0;
      strobe_r   <= 1'b0;
      res_r      <= '0;
    end else begin
      busy_r     <= 1'b0;
      in_valid_r <= accept;
      strobe_r   <= in_valid_r;
      res_r      <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r       <= in_kind;
      address_r    <= in_address;
      write_data_r <= in_write_data;
      channel_r    <= in_channel;
    end
  end

  dmarb_decode u_decode (
    .valid   (in_valid_r),
    .kind    (kind_r),
    .address (address_r),
    .channel (channel_r),
    .dec     (dec)
  );

  dmarb_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .dec   (dec),
    .wdata (write_data_r),
    .res   (res)
  );

  assign out_strobe        = strobe_r;
  assign out_read_data     = res_r.read_data;
  assign out_start_valid   = res_r.start_valid;
  assign out_start_channel = res_r.start_channel;
  assign out_irq           = res_r.irq;

`ifndef SYNTHESIS
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("accepted item gave no result two cycles later");

  a_start_only_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_start_valid |-> (out_strobe && $past(kind_r == KIND_WRITE)))
    else $error("transfer start outside a write result");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |=> !out_strobe)
    else $error("result strobe without an item in flight");
`endif

endmodule

`default_nettype wire
